// ===== design/x2s_pkg.sv =====
// Shared constants for the XYZ to sRGB pixel converter.
// Holds the matrix coefficients, the divide-by-constant reciprocals and the stage count.
// No dependencies.
package x2s_pkg;

  // Pipeline depth from input register to output register
  localparam int unsigned NUM_STAGES = 8;

  // sRGB matrix, coefficients scaled by 1e4, row-major (R, G, B rows)
  localparam int COEF_E4 [9] = '{
    32406, -15372, -4986,
    -9689,  18758,   415,
      557,  -2040, 10570
  };

  // Encoder constants
  localparam int unsigned LIN_GAIN_X100 = 1292;  // 12.92 * 100
  localparam int unsigned POW_GAIN      = 1055;  // 1.055 * 1000
  localparam int unsigned POW_OFS       = 55;    // 0.055 * 1000
  localparam int unsigned OUT_ONE       = 32768; // 1.0 in Q1.15

  // floor(n / 100) = (n * RECIP100) >> RECIP100_SH for n < 2^18
  localparam longint unsigned RECIP100    = 64'd335545;
  localparam int unsigned     RECIP100_SH = 25;
  // floor(m / 1000) = (m * RECIP1000) >> RECIP1000_SH for m < 2^26
  localparam longint unsigned RECIP1000    = 64'd68719477;
  localparam int unsigned     RECIP1000_SH = 36;

  // Coefficient c/1e4 in Q(frac_bits), rounded half away from zero
  function automatic longint coef_fix(input int c, input int frac_bits);
    longint a;
    longint q;
    a = (c < 0) ? -longint'(c) : longint'(c);
    q = ((a << frac_bits) + 64'sd5000) / 64'sd10000;
    return (c < 0) ? -q : q;
  endfunction

endpackage

// ===== design/x2s_gamma_rom.sv =====
// Gamma power table v^(1/2.2) with two registered read ports.
// Contents are built at elaboration from SAMPLE_BITS and GAMMA_TABLE_DEPTH.
// No package dependencies.
module x2s_gamma_rom #(
  parameter int unsigned SAMPLE_BITS       = 16,
  parameter int unsigned GAMMA_TABLE_DEPTH = 1024,
  localparam int unsigned AddrW            = $clog2(GAMMA_TABLE_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [AddrW-1:0]       addr_lo_i,
  input  logic [AddrW-1:0]       addr_hi_i,
  output logic [SAMPLE_BITS:0]   data_lo_o,
  output logic [SAMPLE_BITS:0]   data_hi_o
);

  localparam int unsigned F = SAMPLE_BITS;
  localparam int unsigned D = GAMMA_TABLE_DEPTH;

  // Normalized number: 32-bit mantissa with a binary exponent
  typedef struct packed {
    logic [63:0]        m;
    logic signed [31:0] e;
  } nn_t;

  typedef logic [F:0] tab_t [D+1];

  function automatic nn_t nn_from(input logic [63:0] v);
    nn_t r;
    r.m = v;
    r.e = 0;
    if (v != 64'd0) begin
      while (r.m < 64'h0000_0000_8000_0000) begin
        r.m = r.m << 1;
        r.e = r.e - 1;
      end
      while (r.m >= 64'h0000_0001_0000_0000) begin
        r.m = r.m >> 1;
        r.e = r.e + 1;
      end
    end
    return r;
  endfunction

  function automatic nn_t nn_mul(input nn_t a, input nn_t b);
    nn_t r;
    logic [63:0] p;
    r.m = 64'd0;
    r.e = 0;
    if (a.m != 64'd0 && b.m != 64'd0) begin
      p   = (a.m * b.m) >> 31;
      r.e = a.e + b.e + 31;
      if (p >= 64'h0000_0001_0000_0000) begin
        p   = p >> 1;
        r.e = r.e + 1;
      end
      r.m = p;
    end
    return r;
  endfunction

  function automatic logic nn_le(input nn_t a, input nn_t b);
    logic r;
    if (a.m == 64'd0) r = 1'b1;
    else if (b.m == 64'd0) r = 1'b0;
    else if (a.e != b.e) r = (a.e < b.e);
    else r = (a.m <= b.m);
    return r;
  endfunction

  function automatic nn_t nn_pow(input logic [63:0] v, input int n);
    nn_t base;
    nn_t r;
    base = nn_from(v);
    r    = base;
    for (int i = 1; i < n; i++) begin
      r = nn_mul(r, base);
    end
    return r;
  endfunction

  // Entry i: largest k in 0..2^30 with k^11 * D^5 <= i^5 * 2^330, scaled to QF
  function automatic tab_t build_tab();
    tab_t        t;
    nn_t         d5;
    nn_t         rhs;
    nn_t         lhs;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    d5 = nn_pow(64'(D), 5);
    t[0] = '0;
    for (int i = 1; i <= D; i++) begin
      rhs   = nn_pow(64'(i), 5);
      rhs.e = rhs.e + 330;
      lo    = 64'd0;
      hi    = 64'd1 << 30;
      while (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        lhs = nn_mul(nn_pow(mid, 11), d5);
        if (nn_le(lhs, rhs)) lo = mid;
        else hi = mid - 64'd1;
      end
      t[i] = (F+1)'((lo + (64'd1 << (29 - F))) >> (30 - F));
    end
    return t;
  endfunction

  localparam tab_t GammaTab = build_tab();

  logic [F:0] data_lo_q;
  logic [F:0] data_hi_q;

  // Registered reads
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_lo_q <= GammaTab[addr_lo_i];
      data_hi_q <= GammaTab[addr_hi_i];
    end
  end

  assign data_lo_o = data_lo_q;
  assign data_hi_o = data_hi_q;

endmodule

// ===== design/x2s_chan.sv =====
// One output channel: matrix row, linear/power encoding and clamp.
// Depends on x2s_pkg and x2s_gamma_rom.
module x2s_chan
  import x2s_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS       = 16,
  parameter int unsigned GAMMA_TABLE_DEPTH = 1024,
  parameter int          COEF_X            = 32406,
  parameter int          COEF_Y            = -15372,
  parameter int          COEF_Z            = -4986
) (
  input  logic                  clk_i,
  input  logic [NUM_STAGES-1:0] en_i,     // per-stage load enables
  input  logic [15:0]           x_i,
  input  logic [15:0]           y_i,
  input  logic [15:0]           z_i,
  output logic [15:0]           value_o,
  output logic                  clip_o
);

  localparam int unsigned F     = SAMPLE_BITS;
  localparam int unsigned D     = GAMMA_TABLE_DEPTH;
  localparam int unsigned DW    = $clog2(D + 1);
  localparam int unsigned CW    = F + 3;        // signed coefficient
  localparam int unsigned PW    = F + 20;       // one product
  localparam int unsigned SW    = F + 22;       // row sum
  localparam int unsigned LW    = F + 3;        // linear value, QF
  localparam int unsigned PSW   = F + 1 + DW;   // table position
  localparam longint      ThrL  = ((64'sd31308 <<< F) + 64'sd5000000) / 64'sd10000000;
  localparam int unsigned TW    = $clog2(ThrL + 1);
  localparam int unsigned NW    = TW + 28;      // linear-branch numerator
  localparam int unsigned N_W   = 18;           // linear-branch quotient input
  localparam int unsigned NQW   = N_W + 19;
  localparam int unsigned LOW   = 12;           // linear-branch output
  localparam int unsigned DPW   = 2 * F + 3;
  localparam int unsigned EW    = F + 15;
  localparam int unsigned MW    = F + 26;
  localparam int unsigned M_W   = 26;
  localparam int unsigned MQW   = 53;
  localparam int unsigned QW    = 17;

  localparam logic signed [CW-1:0] CoefX = CW'(coef_fix(COEF_X, F));
  localparam logic signed [CW-1:0] CoefY = CW'(coef_fix(COEF_Y, F));
  localparam logic signed [CW-1:0] CoefZ = CW'(coef_fix(COEF_Z, F));
  localparam logic [LW-1:0]        Thr   = LW'(ThrL);
  localparam logic [LW-1:0]        OneL  = LW'(1) << F;
  localparam logic signed [EW-1:0] K1055 = EW'(POW_GAIN);
  localparam logic signed [EW-1:0] K55   = EW'(POW_OFS) <<< F;

  // Stage 0: three products
  logic signed [PW-1:0] px_q, py_q, pz_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      px_q <= PW'(CoefX * $signed({1'b0, x_i}));
      py_q <= PW'(CoefY * $signed({1'b0, y_i}));
      pz_q <= PW'(CoefZ * $signed({1'b0, z_i}));
    end
  end

  // Stage 1: row sum, sign, round to QF
  logic signed [SW-1:0] sum_d;
  logic signed [SW-1:0] rnd_d;
  logic                 neg1_q;
  logic [LW-1:0]        lin1_q;

  assign sum_d = SW'(px_q) + SW'(py_q) + SW'(pz_q);
  assign rnd_d = sum_d + SW'(1 << 14);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      neg1_q <= sum_d[SW-1];
      lin1_q <= rnd_d[15 +: LW];
    end
  end

  // Stage 2: branch decision, table position, linear-branch numerator
  logic             small_d, over_d;
  logic [F:0]       lin_s_d;
  logic [PSW-1:0]   pos_d;
  logic [NW-1:0]    nprod_d;
  logic [NW-1:0]    nsum_d;
  logic             neg2_q, small2_q, over2_q;
  logic [DW-1:0]    idx2_q;
  logic [F-1:0]     frac2_q;
  logic [N_W-1:0]   n2_q;

  assign small_d = (lin1_q <= Thr);
  assign over_d  = (lin1_q > OneL);
  assign lin_s_d = over_d ? OneL[F:0] : lin1_q[F:0];
  assign pos_d   = PSW'(lin_s_d) * PSW'(D);
  assign nprod_d = NW'(lin1_q[TW-1:0]) * NW'(LIN_GAIN_X100);
  assign nsum_d  = (nprod_d << 15) + (NW'(50) << F);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      neg2_q   <= neg1_q;
      small2_q <= small_d;
      over2_q  <= over_d;
      idx2_q   <= pos_d[F +: DW];
      frac2_q  <= pos_d[F-1:0];
      n2_q     <= nsum_d[F +: N_W];
    end
  end

  // Stage 3: table reads at idx and idx+1 (last entry repeats at the end)
  logic [DW-1:0] addr_hi_d;
  logic [F:0]    t0_3, t1_3;
  logic          neg3_q, small3_q, over3_q;
  logic [F-1:0]  frac3_q;
  logic [N_W-1:0] n3_q;

  assign addr_hi_d = (idx2_q == DW'(D)) ? DW'(D) : idx2_q + DW'(1);

  x2s_gamma_rom #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .GAMMA_TABLE_DEPTH(GAMMA_TABLE_DEPTH)
  ) u_rom (
    .clk_i    (clk_i),
    .en_i     (en_i[3]),
    .addr_lo_i(idx2_q),
    .addr_hi_i(addr_hi_d),
    .data_lo_o(t0_3),
    .data_hi_o(t1_3)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      neg3_q   <= neg2_q;
      small3_q <= small2_q;
      over3_q  <= over2_q;
      frac3_q  <= frac2_q;
      n3_q     <= n2_q;
    end
  end

  // Stage 4: slope times fraction, linear branch reciprocal product
  logic signed [F+1:0]  d_d;
  logic signed [DPW-1:0] dp_d;
  logic signed [DPW-1:0] dp4_q;
  logic [F:0]           t04_q;
  logic [NQW-1:0]       nq4_q;
  logic                 neg4_q, small4_q, over4_q;

  assign d_d  = $signed({1'b0, t1_3}) - $signed({1'b0, t0_3});
  assign dp_d = DPW'(d_d * $signed({1'b0, frac3_q}));

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      dp4_q    <= dp_d;
      t04_q    <= t0_3;
      nq4_q    <= NQW'(n3_q) * NQW'(RECIP100);
      neg4_q   <= neg3_q;
      small4_q <= small3_q;
      over4_q  <= over3_q;
    end
  end

  // Stage 5: interpolate (truncate toward zero), scale and offset
  logic signed [DPW-1:0] dsum_d;
  logic signed [F+2:0]   p_d;
  logic signed [EW-1:0]  e_d;
  logic signed [EW-1:0]  e5_q;
  logic [LOW-1:0]        lo5_q;
  logic                  neg5_q, small5_q, over5_q;

  assign dsum_d = dp4_q + (dp4_q[DPW-1] ? $signed({{(F+3){1'b0}}, {F{1'b1}}}) : '0);
  assign p_d    = $signed({2'b00, t04_q}) + $signed(dsum_d[DPW-1:F]);
  assign e_d    = EW'(p_d) * K1055 - K55;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      e5_q     <= e_d;
      lo5_q    <= nq4_q[RECIP100_SH +: LOW];
      neg5_q   <= neg4_q;
      small5_q <= small4_q;
      over5_q  <= over4_q;
    end
  end

  // Stage 6: to Q1.15 with rounding, reciprocal product for /1000
  logic [MW-1:0]  mm_d;
  logic [MQW-1:0] mq6_q;
  logic           epos6_q, eneg6_q;
  logic [LOW-1:0] lo6_q;
  logic           neg6_q, small6_q, over6_q;

  assign mm_d = (MW'(e5_q[F+9:0]) << 15) + (MW'(500) << F);

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      mq6_q    <= MQW'(mm_d[F +: M_W]) * MQW'(RECIP1000);
      epos6_q  <= (e5_q > 0);
      eneg6_q  <= e5_q[EW-1];
      lo6_q    <= lo5_q;
      neg6_q   <= neg5_q;
      small6_q <= small5_q;
      over6_q  <= over5_q;
    end
  end

  // Stage 7: branch select and clamp
  logic [QW-1:0] q_d;
  logic [15:0]   val_d;
  logic          clip_d;
  logic [15:0]   val7_q;
  logic          clip7_q;

  assign q_d = mq6_q[RECIP1000_SH +: QW];

  always_comb begin
    priority if (neg6_q) begin
      val_d  = '0;
      clip_d = 1'b1;
    end else if (small6_q) begin
      val_d  = 16'(lo6_q);
      clip_d = 1'b0;
    end else if (!epos6_q) begin
      val_d  = '0;
      clip_d = eneg6_q || over6_q;
    end else if (q_d > QW'(OUT_ONE)) begin
      val_d  = 16'(OUT_ONE);
      clip_d = 1'b1;
    end else begin
      val_d  = q_d[15:0];
      clip_d = over6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      val7_q  <= val_d;
      clip7_q <= clip_d;
    end
  end

  assign value_o = val7_q;
  assign clip_o  = clip7_q;

endmodule

// ===== design/xyz_to_srgb_pixel.sv =====
// XYZ to sRGB pixel converter, 8-stage pipeline with a stream interface.
// Throughput one item per cycle while the output is not back-pressured (m_axis_tready high).
// Each stage loads when it is empty or the stage after it moves, so bubbles are squeezed out.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data registers are not reset.
// The gamma table is a constant ROM per channel, built at elaboration; no warm-up after reset.
// Depends on x2s_pkg, x2s_chan and x2s_gamma_rom.
module xyz_to_srgb_pixel
  import x2s_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS       = 16,
  parameter int unsigned GAMMA_TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] x_in, [31:16] y_in, [47:32] z_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] red, [31:16] green, [47:32] blue
  output logic        m_axis_tuser    // [0] clipped
);

  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] en;
  logic [15:0]           val [3];
  logic [2:0]            clip;

  // Stage enables: a stage loads when empty or when its successor loads
  always_comb begin
    en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // One datapath per output channel
  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    x2s_chan #(
      .SAMPLE_BITS      (SAMPLE_BITS),
      .GAMMA_TABLE_DEPTH(GAMMA_TABLE_DEPTH),
      .COEF_X           (COEF_E4[ch*3]),
      .COEF_Y           (COEF_E4[ch*3+1]),
      .COEF_Z           (COEF_E4[ch*3+2])
    ) u_chan (
      .clk_i  (clk_i),
      .en_i   (en),
      .x_i    (s_axis_tdata[15:0]),
      .y_i    (s_axis_tdata[31:16]),
      .z_i    (s_axis_tdata[47:32]),
      .value_o(val[ch]),
      .clip_o (clip[ch])
    );
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NUM_STAGES-1];
  assign m_axis_tdata  = {val[2], val[1], val[0]};
  assign m_axis_tuser  = |clip;

endmodule

// ===== sim/xyz_to_srgb_pixel_chk.sv =====
// Checker for the XYZ to sRGB pixel converter: watches both stream channels,
// predicts each output pixel from the accepted input pixel and compares them.
// Depends on x2s_pkg for the matrix coefficients.
`timescale 1ns / 100ps

module xyz_to_srgb_pixel_chk
  import x2s_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] x_in, [31:16] y_in, [47:32] z_in
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // [15:0] red, [31:16] green, [47:32] blue
  input  logic        m_axis_tuser,   // [0] clipped
  output int          errors_o,
  output int          pending_o
);

  localparam int unsigned FB    = 16;    // fraction bits of the linear value
  localparam int unsigned DEPTH = 1024;  // gamma table segments
  localparam logic [63:0] ONE   = 64'd1 << FB;
  localparam int unsigned MAX_PRINTS = 100;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        clipped;
  } srgb_t;

  // Normalized number: 32-bit mantissa in [2^31, 2^32) and a binary exponent
  typedef struct packed {
    logic [63:0]        m;
    logic signed [31:0] e;
  } norm_t;

  longint      coef_q [9];
  logic [63:0] gamma_lut [DEPTH+1];
  logic [63:0] thr_q;
  srgb_t       expected_q [$];
  int          error_total;

  function automatic norm_t norm_of(input logic [63:0] v);
    norm_t r;
    r.m = v;
    r.e = 0;
    if (v != 0) begin
      while (r.m < (64'd1 << 31)) begin
        r.m = r.m << 1;
        r.e = r.e - 1;
      end
      while (r.m >= (64'd1 << 32)) begin
        r.m = r.m >> 1;
        r.e = r.e + 1;
      end
    end
    return r;
  endfunction

  // Product keeps 32 mantissa bits, truncated
  function automatic norm_t norm_mul(input norm_t a, input norm_t b);
    norm_t       r;
    logic [63:0] p;
    r.m = 0;
    r.e = 0;
    if (a.m != 0 && b.m != 0) begin
      p   = (a.m * b.m) >> 31;
      r.e = a.e + b.e + 31;
      if (p >= (64'd1 << 32)) begin
        p   = p >> 1;
        r.e = r.e + 1;
      end
      r.m = p;
    end
    return r;
  endfunction

  function automatic logic norm_le(input norm_t a, input norm_t b);
    if (a.m == 0) return 1'b1;
    if (b.m == 0) return 1'b0;
    if (a.e != b.e) return $signed(a.e) < $signed(b.e);
    return a.m <= b.m;
  endfunction

  function automatic norm_t norm_pow(input logic [63:0] v, input int n);
    norm_t b;
    norm_t r;
    b = norm_of(v);
    r = b;
    for (int i = 1; i < n; i++) r = norm_mul(r, b);
    return r;
  endfunction

  // Table of (i/DEPTH)^(1/2.2): largest k with k^11 * DEPTH^5 <= i^5 * 2^330
  function automatic void build_gamma_lut();
    norm_t       d5;
    norm_t       rhs;
    norm_t       lhs;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    d5 = norm_pow(DEPTH, 5);
    gamma_lut[0] = 0;
    for (int i = 1; i <= DEPTH; i++) begin
      rhs   = norm_pow(i, 5);
      rhs.e = rhs.e + 330;
      lo    = 0;
      hi    = 64'd1 << 30;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = norm_mul(norm_pow(mid, 11), d5);
        if (norm_le(lhs, rhs)) lo = mid;
        else hi = mid - 1;
      end
      gamma_lut[i] = (lo + (64'd1 << (29 - FB))) >> (30 - FB);
    end
  endfunction

  // Gamma-encode one channel from its Q(FB+15) matrix sum
  function automatic logic [15:0] encode_gamma(input longint sum, inout logic clip);
    logic [63:0] lin;
    logic [63:0] pos;
    logic [63:0] idx;
    logic [63:0] f;
    logic [63:0] q;
    longint      diff;
    longint      p;
    longint      e;
    if (sum < 0) begin
      clip = 1'b1;
      return 16'd0;
    end
    lin = (64'(sum) + (64'd1 << 14)) >> 15;
    // linear segment near black
    if (lin <= thr_q) begin
      q = (lin * 64'd1292 * 64'd32768 + (64'd50 << FB)) / (64'd100 << FB);
      return q[15:0];
    end
    if (lin > ONE) begin
      clip = 1'b1;
      lin  = ONE;
    end
    pos = lin * DEPTH;
    idx = pos >> FB;
    if (idx >= DEPTH) begin
      p = longint'(gamma_lut[DEPTH]);
    end else begin
      diff = longint'(gamma_lut[idx+1]) - longint'(gamma_lut[idx]);
      f    = pos & (ONE - 1);
      p    = longint'(gamma_lut[idx]) + diff * longint'(f) / longint'(ONE);
    end
    e = p * 64'sd1055 - (64'sd55 << FB);
    // coarse interpolation can land below the offset
    if (e <= 0) begin
      if (e < 0) clip = 1'b1;
      return 16'd0;
    end
    q = (64'(e) * 64'd32768 + (64'd500 << FB)) / (64'd1000 << FB);
    if (q > 64'd32768) begin
      clip = 1'b1;
      q    = 64'd32768;
    end
    return q[15:0];
  endfunction

  function automatic srgb_t predict_pixel(input logic [47:0] xyz);
    srgb_t       r;
    logic        clip;
    longint      comp [3];
    longint      sum;
    logic [15:0] chan [3];
    clip = 1'b0;
    for (int k = 0; k < 3; k++) comp[k] = longint'({48'd0, xyz[16*k +: 16]});
    for (int c = 0; c < 3; c++) begin
      sum = coef_q[3*c] * comp[0] + coef_q[3*c+1] * comp[1] + coef_q[3*c+2] * comp[2];
      chan[c] = encode_gamma(sum, clip);
    end
    r.red     = chan[0];
    r.green   = chan[1];
    r.blue    = chan[2];
    r.clipped = clip;
    return r;
  endfunction

  task automatic report_fail(input string msg);
    if (error_total < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    error_total++;
  endtask

  // Constant tables, rounded half away from zero like the hardware
  initial begin
    longint a;
    longint q;
    error_total = 0;
    errors_o    = 0;
    pending_o   = 0;
    for (int i = 0; i < 9; i++) begin
      a = (COEF_E4[i] < 0) ? -longint'(COEF_E4[i]) : longint'(COEF_E4[i]);
      q = ((a << FB) + 64'sd5000) / 64'sd10000;
      coef_q[i] = (COEF_E4[i] < 0) ? -q : q;
    end
    thr_q = ((64'd31308 << FB) + 64'd5000000) / 64'd10000000;
    build_gamma_lut();
  end

  // Sample both channels at each edge
  always @(posedge clk_i) begin
    srgb_t       got;
    srgb_t       want;
    logic [15:0] got_f [4];
    logic [15:0] want_f [4];
    string       names [4];
    names = '{"red", "green", "blue", "clipped"};
    if (rst_ni === 1'b1) begin
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(predict_pixel(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32], m_axis_tuser};
        if (expected_q.size() == 0) begin
          report_fail($sformatf("output pixel %h with nothing expected", m_axis_tdata));
        end else begin
          want      = expected_q.pop_front();
          got_f     = '{got.red, got.green, got.blue, {15'd0, got.clipped}};
          want_f    = '{want.red, want.green, want.blue, {15'd0, want.clipped}};
          for (int k = 0; k < 4; k++) begin
            if (got_f[k] !== want_f[k])
              report_fail($sformatf("%s got %0d expected %0d", names[k], got_f[k], want_f[k]));
          end
        end
      end
      errors_o  = error_total;
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== sim/xyz_to_srgb_pixel_tb.sv =====
// Testbench top for the XYZ to sRGB pixel converter: clock, reset, input pixels,
// output back-pressure and the verdict. Depends on x2s_pkg, the block and
// xyz_to_srgb_pixel_chk, which does the prediction and comparison.
`timescale 1ns / 100ps

module xyz_to_srgb_pixel_tb;
  import x2s_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned NUM_DIRECTED = 22;

  // Directed pixels, packed {z, y, x}
  localparam logic [47:0] DIRECTED [NUM_DIRECTED] = '{
    {16'd0,     16'd0,     16'd0},      // black
    {16'hFFFF,  16'hFFFF,  16'hFFFF},   // all fields at max
    {16'd0,     16'd0,     16'hFFFF},
    {16'd0,     16'hFFFF,  16'd0},
    {16'hFFFF,  16'd0,     16'd0},
    {16'd0,     16'd0,     16'd1},
    {16'd1,     16'd1,     16'd1},
    {16'd0,     16'd1,     16'd0},
    {16'd0,     16'd0,     16'd31},     // red just below the linear threshold
    {16'd0,     16'd0,     16'd32},     // red just above it
    {16'd223,   16'd205,   16'd195},    // gray near the threshold
    {16'd229,   16'd210,   16'd200},
    {16'd35685, 16'd32768, 16'd31146},  // white point, channels near 1.0
    {16'd17842, 16'd16384, 16'd15573},  // mid gray
    {16'd31000, 16'd0,     16'd0},      // blue just under 1.0
    {16'd31001, 16'd0,     16'd0},      // blue just over 1.0
    {16'd0,     16'd0,     16'd8000},
    {16'h8000,  16'h8000,  16'h8000},
    {16'h5555,  16'hAAAA,  16'h5555},
    {16'hAAAA,  16'h5555,  16'hAAAA},
    {16'd36000, 16'd33000, 16'd31500},  // slightly over white
    {16'd0,     16'd40000, 16'd0}       // green saturates, others negative
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // [15:0] x_in, [31:16] y_in, [47:32] z_in
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [15:0] red, [31:16] green, [47:32] blue
  logic        m_axis_tuser;   // [0] clipped
  int          error_count;
  int          pending_count;
  int unsigned cycle_count = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  xyz_to_srgb_pixel DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  xyz_to_srgb_pixel_chk u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors_o      (error_count),
    .pending_o     (pending_count)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Idle cycles between input items: mostly none or short, a few long
  function automatic int unsigned input_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 96) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Offer one pixel and hold it until accepted
  task automatic send_pixel(input logic [47:0] xyz);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= xyz;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Idle before the next item; a zero gap keeps tvalid high
  task automatic idle_input(input int unsigned gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Output back-pressure in random segments, plus two long hold-offs
  initial begin : sink
    int unsigned mode;
    int unsigned span;
    int unsigned sink_cycles;
    int unsigned holds;
    m_axis_tready <= 1'b0;
    sink_cycles = 0;
    holds       = 0;
    @(posedge rst_ni);
    forever begin
      if ((holds == 0 && sink_cycles >= 400) || (holds == 1 && sink_cycles >= 2000)) begin
        // long stall: the pipeline fills and the input must stop
        repeat (150) begin
          @(posedge clk_i);
          m_axis_tready <= 1'b0;
          sink_cycles++;
        end
        holds++;
      end
      mode = $urandom_range(0, 9);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk_i);
        if (mode < 3) m_axis_tready <= 1'b1;
        else if (mode < 8) m_axis_tready <= ($urandom_range(0, 9) < 7);
        else m_axis_tready <= ($urandom_range(0, 9) == 0);
        sink_cycles++;
      end
    end
  end

  // Reset, stimulus and verdict
  initial begin : stimulus
    int unsigned kind;
    int unsigned lim;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        burst;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    burst = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < NUM_DIRECTED; n++) begin
      idle_input(input_gap());
      send_pixel(DIRECTED[n]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        // in-gamut pixel: random linear RGB through the forward matrix
        lim = (kind == 0) ? 400 : 32768;
        r = $urandom_range(0, lim);
        g = $urandom_range(0, lim);
        b = $urandom_range(0, lim);
        x = 16'((4124 * r + 3576 * g + 1805 * b) / 10000);
        y = 16'((2126 * r + 7152 * g + 722 * b) / 10000);
        z = 16'((193 * r + 1192 * g + 9505 * b) / 10000);
      end else if (kind < 9) begin
        x = 16'($urandom_range(0, 65535));
        y = 16'($urandom_range(0, 65535));
        z = 16'($urandom_range(0, 65535));
      end else begin
        x = 16'($urandom_range(0, 300));
        y = 16'($urandom_range(0, 300));
        z = 16'($urandom_range(0, 300));
      end
      idle_input(burst ? 0 : input_gap());
      send_pixel({z, y, x});
    end
    s_axis_tvalid <= 1'b0;

    // drain the pipeline
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4 * NUM_STAGES) @(posedge clk_i);

    if (error_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/x2s_pkg.sv
design/x2s_gamma_rom.sv
design/x2s_chan.sv
design/xyz_to_srgb_pixel.sv
sim/xyz_to_srgb_pixel_chk.sv
sim/xyz_to_srgb_pixel_tb.sv
